### design/rcc_pkg.sv
// shared types and constants for the rc channel conditioner
`default_nettype none

package rcc_pkg;

	typedef enum logic [2:0] {
		KIND_STICK = 3'd0,
		KIND_POT   = 3'd1,
		KIND_TWO   = 3'd2,
		KIND_THREE = 3'd3,
		KIND_SIX   = 3'd4
	} kind_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_CTR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_HALF   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SW_LOW      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SW_HIGH     = 3'd6;

	localparam logic [11:0] RST_PULSE_MIN  = 12'd1000;
	localparam logic [11:0] RST_PULSE_MAX  = 12'd2000;
	localparam logic [11:0] RST_PULSE_CTR  = 12'd1500;
	localparam logic [9:0]  RST_DEAD_HALF  = 10'd20;
	localparam logic [14:0] RST_FULL_SCALE = 15'd1000;
	localparam logic [11:0] RST_SW_LOW     = 12'd1250;
	localparam logic [11:0] RST_SW_HIGH    = 12'd1750;

	localparam int PULSE_W = 12;
	localparam int VALUE_W = 16;
	localparam int OP_W    = 14;
	localparam int MULB_W  = 15;
	localparam int PROD_W  = OP_W + MULB_W + 1;
	localparam int NUM_W   = PROD_W + 1;
	localparam int QMAG_W  = 28;
	localparam int DMAG_W  = 13;
	localparam int SUM_W   = 30;
	localparam int DIV_STEPS = QMAG_W / 2;
	localparam int CNT_W   = 4;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef struct packed {
		logic [11:0] pulse_min;
		logic [11:0] pulse_max;
		logic [11:0] pulse_center;
		logic [9:0]  dead_half_width;
		logic [14:0] full_scale;
		logic [11:0] switch_low_level;
		logic [11:0] switch_high_level;
	} cfg_t;

	typedef struct packed {
		logic                      direct;
		logic                      fault;
		logic                      detent;
		logic signed [VALUE_W-1:0] base;
		logic signed [OP_W-1:0]    mul_a;
		logic [MULB_W-1:0]         mul_b;
		logic signed [OP_W-1:0]    addend;
		logic signed [OP_W-1:0]    den;
	} job_t;

endpackage

`default_nettype wire

### design/rcc_front.sv
// front end: accepts a pulse, clamps it and turns it into a mapping job
`default_nettype none

module rcc_front #(
	parameter int DETENT_STEPS = 5
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [2:0]                     command,
	input  wire logic [rcc_pkg::PULSE_W-1:0]    pulse_width,
	input  wire rcc_pkg::cfg_t                  cfg,
	input  wire logic [rcc_pkg::QCNT_W-1:0]     queue_count,
	output logic                                busy,
	output logic                                push,
	output rcc_pkg::job_t                       push_data
);

	localparam int OP_W = rcc_pkg::OP_W;

	logic                          valid_s1;
	logic [2:0]                    cmd_s1;
	logic [rcc_pkg::PULSE_W-1:0]   p_s1;
	logic [rcc_pkg::PULSE_W-1:0]   p_clamped;
	logic                          accept;

	logic signed [OP_W-1:0] p_s, lo_s, hi_s, ctr_s, dhw_s, db_lo, db_hi, r_s, r_adj;
	logic signed [rcc_pkg::VALUE_W-1:0] fs_s;
	rcc_pkg::job_t job;

	assign busy   = (rcc_pkg::QCNT_W'(queue_count) + rcc_pkg::QCNT_W'(valid_s1))
		>= rcc_pkg::QCNT_W'(rcc_pkg::QUEUE_DEPTH);
	assign accept = start && !busy;

	always_comb begin
		if (pulse_width < cfg.pulse_min) begin
			p_clamped = cfg.pulse_min;
		end else if (pulse_width > cfg.pulse_max) begin
			p_clamped = cfg.pulse_max;
		end else begin
			p_clamped = pulse_width;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= command;
			p_s1   <= p_clamped;
		end
	end

	// operand selection for the shared multiply and divide
	always_comb begin
		p_s   = $signed({2'b00, p_s1});
		lo_s  = $signed({2'b00, cfg.pulse_min});
		hi_s  = $signed({2'b00, cfg.pulse_max});
		ctr_s = $signed({2'b00, cfg.pulse_center});
		dhw_s = $signed({4'b0000, cfg.dead_half_width});
		fs_s  = $signed({1'b0, cfg.full_scale});
		db_lo = ctr_s - dhw_s;
		db_hi = ctr_s + dhw_s;
		r_s   = hi_s - lo_s;
		r_adj = r_s + $signed({{(OP_W-1){1'b0}}, r_s[OP_W-1]});

		job        = '0;
		job.direct = 1'b1;
		job.den    = OP_W'(1);

		unique case (rcc_pkg::kind_t'(cmd_s1))
			rcc_pkg::KIND_STICK: begin
				if (p_s < db_lo) begin
					job.direct = 1'b0;
					job.mul_a  = p_s - lo_s;
					job.den    = db_lo - lo_s;
					job.base   = -fs_s;
					job.mul_b  = cfg.full_scale;
				end else if (p_s > db_hi) begin
					job.direct = 1'b0;
					job.mul_a  = p_s - db_hi;
					job.den    = hi_s - db_hi;
					job.mul_b  = cfg.full_scale;
				end
			end
			rcc_pkg::KIND_POT: begin
				job.direct = 1'b0;
				job.mul_b  = cfg.full_scale;
				if (p_s <= ctr_s) begin
					job.mul_a = p_s - lo_s;
					job.den   = ctr_s - lo_s;
					job.base  = -fs_s;
				end else begin
					job.mul_a = p_s - ctr_s;
					job.den   = hi_s - ctr_s;
				end
			end
			rcc_pkg::KIND_TWO: begin
				job.base = (p_s1 >= cfg.pulse_center) ? 16'sd1 : 16'sd0;
			end
			rcc_pkg::KIND_THREE: begin
				if (p_s1 <= cfg.switch_low_level) begin
					job.base = -16'sd1;
				end else if (p_s1 >= cfg.switch_high_level) begin
					job.base = 16'sd1;
				end
			end
			rcc_pkg::KIND_SIX: begin
				job.direct = 1'b0;
				job.detent = 1'b1;
				job.mul_a  = p_s - lo_s;
				job.mul_b  = rcc_pkg::MULB_W'(DETENT_STEPS);
				job.den    = r_s;
				job.addend = r_adj >>> 1;
			end
			default: begin
				job.base = '0;
			end
		endcase

		if (!job.direct && job.den == '0) begin
			job.direct = 1'b1;
			job.fault  = 1'b1;
			job.base   = '0;
		end
	end

	assign push      = valid_s1;
	assign push_data = job;

`ifndef NO_ASSERTIONS
	a_accept_reaches_queue: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> push)
		else $error("accepted item did not reach the queue");
`endif

endmodule

`default_nettype wire

### design/rcc_queue.sv
// short job queue between front and back end
`default_nettype none

module rcc_queue (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire rcc_pkg::job_t               push_data,
	input  wire logic                        pop,
	output rcc_pkg::job_t                    head,
	output logic                             empty,
	output logic [rcc_pkg::QCNT_W-1:0]       count
);

	rcc_pkg::job_t entries_q [rcc_pkg::QUEUE_DEPTH];
	logic [rcc_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [rcc_pkg::QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + rcc_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + rcc_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + rcc_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - rcc_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	assign head  = entries_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

`ifndef NO_ASSERTIONS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < rcc_pkg::QCNT_W'(rcc_pkg::QUEUE_DEPTH)))
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

### design/rcc_back.sv
// back end: multiply, radix-4 signed divide, offset and saturate
`default_nettype none

module rcc_back #(
	parameter int DETENT_STEPS = 5
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                empty,
	input  wire rcc_pkg::job_t                       head,
	output logic                                     pop,
	output logic                                     done,
	output logic signed [rcc_pkg::VALUE_W-1:0]       value,
	output logic                                     div_fault
);

	localparam int QMAG_W = rcc_pkg::QMAG_W;
	localparam int DMAG_W = rcc_pkg::DMAG_W;
	localparam int SUM_W  = rcc_pkg::SUM_W;
	localparam logic signed [SUM_W-1:0] DET_MAX   = SUM_W'(DETENT_STEPS);
	localparam logic signed [SUM_W-1:0] OUT_LIMIT = SUM_W'(32767);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_PREP,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   done_q, fault_q;
	logic signed [rcc_pkg::VALUE_W-1:0] value_q;

	rcc_pkg::job_t job_q;
	logic signed [rcc_pkg::NUM_W-1:0] num_q;
	logic [QMAG_W-1:0]  work_q;
	logic [DMAG_W-1:0]  rem_q, dmag_q;
	logic               neg_q;
	logic [rcc_pkg::CNT_W-1:0] cnt_q;

	logic signed [rcc_pkg::PROD_W-1:0] prod;
	logic signed [rcc_pkg::NUM_W-1:0]  num_d, num_abs;
	logic signed [rcc_pkg::OP_W-1:0]   den_abs;
	logic [QMAG_W-1:0]  work_d;
	logic [DMAG_W-1:0]  rem_d;
	logic [DMAG_W:0]    trial;
	logic signed [QMAG_W:0]  q_s, q_v;
	logic signed [SUM_W-1:0] sum, sat;

	assign pop = (state_q == ST_IDLE) && !empty;

	always_comb begin
		prod    = job_q.mul_a * $signed({1'b0, job_q.mul_b});
		num_d   = prod + job_q.addend;
		num_abs = num_q[rcc_pkg::NUM_W-1] ? -num_q : num_q;
		den_abs = job_q.den[rcc_pkg::OP_W-1] ? -job_q.den : job_q.den;
	end

	// two restoring steps per cycle
	always_comb begin
		rem_d  = rem_q;
		work_d = work_q;
		trial  = '0;
		for (int k = 0; k < 2; k++) begin
			trial  = {rem_d, work_d[QMAG_W-1]};
			work_d = {work_d[QMAG_W-2:0], 1'b0};
			if (trial >= {1'b0, dmag_q}) begin
				trial     = trial - {1'b0, dmag_q};
				work_d[0] = 1'b1;
			end
			rem_d = trial[DMAG_W-1:0];
		end
	end

	always_comb begin
		q_s = $signed({1'b0, work_q});
		q_v = neg_q ? -q_s : q_s;
		sum = SUM_W'(job_q.base) + SUM_W'(q_v);
		if (job_q.detent) begin
			priority if (sum < 0) begin
				sat = '0;
			end else if (sum > DET_MAX) begin
				sat = DET_MAX;
			end else begin
				sat = sum;
			end
		end else begin
			priority if (sum < -OUT_LIMIT) begin
				sat = -OUT_LIMIT;
			end else if (sum > OUT_LIMIT) begin
				sat = OUT_LIMIT;
			end else begin
				sat = sum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			fault_q <= 1'b0;
			value_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (head.direct) begin
							done_q  <= 1'b1;
							value_q <= head.base;
							fault_q <= head.fault;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == rcc_pkg::CNT_W'(rcc_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					value_q <= sat[rcc_pkg::VALUE_W-1:0];
					fault_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
		if (state_q == ST_MUL) begin
			num_q <= num_d;
		end
		if (state_q == ST_PREP) begin
			work_q <= num_abs[QMAG_W-1:0];
			dmag_q <= den_abs[DMAG_W-1:0];
			rem_q  <= '0;
			neg_q  <= num_q[rcc_pkg::NUM_W-1] ^ job_q.den[rcc_pkg::OP_W-1];
			cnt_q  <= '0;
		end
		if (state_q == ST_DIV) begin
			work_q <= work_d;
			rem_q  <= rem_d;
			cnt_q  <= cnt_q + rcc_pkg::CNT_W'(1);
		end
	end

	assign done      = done_q;
	assign value     = value_q;
	assign div_fault = fault_q;

`ifndef NO_ASSERTIONS
	a_value_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (value != 16'sh8000))
		else $error("result outside symmetric range");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q < rcc_pkg::CNT_W'(rcc_pkg::DIV_STEPS)))
		else $error("divide step count overrun");
`endif

endmodule

`default_nettype wire

### design/rc_channel_conditioner_core.sv
// top level of the rc channel conditioner: configuration registers and datapath
`default_nettype none

// Converts one receiver pulse width and a channel kind into one signed value.
// Input: start with command and pulse_width; a transfer happens at a clock
// edge with start high and busy low. Results: done is high for one cycle with
// value and div_fault; the receiver cannot stall, every result is taken.
// Configuration: cfg_valid, cfg_index, cfg_data; cfg_ready is always high, so
// a write lands at any edge with cfg_valid high. Write only while idle.
// Path: switch kinds, the deadband, faults and unknown kinds go through the
// input register, the queue and the result register; stick, potentiometer
// and six-state mappings also pass the multiply, prepare, divide and finish states.
// Throughput: the front takes one item per cycle until its four-entry queue
// fills; the back end finishes a direct item each cycle and takes no new item
// until a mapped item has gone through the radix-4 divider and its finish state.
// Reset: the registers return to their default values, the queue empties
// and no result is pending.
module rc_channel_conditioner_core #(
	parameter int DETENT_STEPS = 5
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic [2:0]                           command,
	input  wire logic [rcc_pkg::PULSE_W-1:0]          pulse_width,
	output logic                                      done,
	output logic signed [rcc_pkg::VALUE_W-1:0]        value,
	output logic                                      div_fault,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [rcc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [rcc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	rcc_pkg::cfg_t cfg_q;
	rcc_pkg::job_t push_data, head;
	logic push, pop, empty;
	logic [rcc_pkg::QCNT_W-1:0] queue_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_min         <= rcc_pkg::RST_PULSE_MIN;
			cfg_q.pulse_max         <= rcc_pkg::RST_PULSE_MAX;
			cfg_q.pulse_center      <= rcc_pkg::RST_PULSE_CTR;
			cfg_q.dead_half_width   <= rcc_pkg::RST_DEAD_HALF;
			cfg_q.full_scale        <= rcc_pkg::RST_FULL_SCALE;
			cfg_q.switch_low_level  <= rcc_pkg::RST_SW_LOW;
			cfg_q.switch_high_level <= rcc_pkg::RST_SW_HIGH;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rcc_pkg::REG_PULSE_MIN:  cfg_q.pulse_min         <= cfg_data[11:0];
				rcc_pkg::REG_PULSE_MAX:  cfg_q.pulse_max         <= cfg_data[11:0];
				rcc_pkg::REG_PULSE_CTR:  cfg_q.pulse_center      <= cfg_data[11:0];
				rcc_pkg::REG_DEAD_HALF:  cfg_q.dead_half_width   <= cfg_data[9:0];
				rcc_pkg::REG_FULL_SCALE: cfg_q.full_scale        <= cfg_data[14:0];
				rcc_pkg::REG_SW_LOW:     cfg_q.switch_low_level  <= cfg_data[11:0];
				rcc_pkg::REG_SW_HIGH:    cfg_q.switch_high_level <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

	rcc_front #(
		.DETENT_STEPS(DETENT_STEPS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.command    (command),
		.pulse_width(pulse_width),
		.cfg        (cfg_q),
		.queue_count(queue_count),
		.busy       (busy),
		.push       (push),
		.push_data  (push_data)
	);

	rcc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.count    (queue_count)
	);

	rcc_back #(
		.DETENT_STEPS(DETENT_STEPS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.head     (head),
		.pop      (pop),
		.done     (done),
		.value    (value),
		.div_fault(div_fault)
	);

endmodule

`default_nettype wire

### test/tb_rc_channel_conditioner_core.sv
// testbench for rc_channel_conditioner_core: directed table, then preset and random register values
module tb_rc_channel_conditioner_core;
	import rcc_pkg::*;

	localparam int DETENTS         = 5;
	localparam int OUT_MAG         = 32767;
	localparam int NUM_PRESETS     = 6;
	localparam int NUM_PHASES      = 14;
	localparam int ITEMS_PER_PHASE = 120;
	localparam int NUM_DIRECTED    = 25;
	localparam int QUIET_FIRST     = 700;
	localparam int QUIET_LAST      = 1000;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic [2:0] CMD_RSVD_5 = 3'd5;
	localparam logic [2:0] CMD_RSVD_6 = 3'd6;
	localparam logic [2:0] CMD_RSVD_7 = 3'd7;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      fault;
	} channel_out_t;

	typedef struct packed {
		logic [2:0]           cmd;
		logic [PULSE_W-1:0]   pw;
		logic                 typed;
		channel_out_t         want;
	} pulse_case_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] command = '0;
	logic [PULSE_W-1:0] pulse_width = '0;
	logic cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic busy;
	logic done;
	logic signed [VALUE_W-1:0] value;
	logic div_fault;
	logic cfg_ready;

	cfg_t         shadow_cfg;
	channel_out_t pending_results[$];
	int           fail_count = 0;
	int           items_sent = 0;

	pulse_case_t directed_cases [NUM_DIRECTED] = '{
		'{KIND_STICK, 12'd0,    1'b1, '{-16'sd1000, 1'b0}},
		'{KIND_STICK, 12'd4095, 1'b1, '{16'sd1000, 1'b0}},
		'{KIND_STICK, 12'd1500, 1'b1, '{16'sd0, 1'b0}},
		'{KIND_STICK, 12'd1480, 1'b1, '{16'sd0, 1'b0}},
		'{KIND_STICK, 12'd1520, 1'b1, '{16'sd0, 1'b0}},
		'{KIND_STICK, 12'd1479, 1'b0, '{16'sd0, 1'b0}},
		'{KIND_STICK, 12'd1521, 1'b0, '{16'sd0, 1'b0}},
		'{KIND_POT,   12'd0,    1'b1, '{-16'sd1000, 1'b0}},
		'{KIND_POT,   12'd4095, 1'b1, '{16'sd1000, 1'b0}},
		'{KIND_POT,   12'd1500, 1'b1, '{16'sd0, 1'b0}},
		'{KIND_POT,   12'd1501, 1'b0, '{16'sd0, 1'b0}},
		'{KIND_POT,   12'd1234, 1'b0, '{16'sd0, 1'b0}},
		'{KIND_TWO,   12'd1499, 1'b1, '{16'sd0, 1'b0}},
		'{KIND_TWO,   12'd1500, 1'b1, '{16'sd1, 1'b0}},
		'{KIND_THREE, 12'd1250, 1'b1, '{-16'sd1, 1'b0}},
		'{KIND_THREE, 12'd1251, 1'b1, '{16'sd0, 1'b0}},
		'{KIND_THREE, 12'd1749, 1'b1, '{16'sd0, 1'b0}},
		'{KIND_THREE, 12'd1750, 1'b1, '{16'sd1, 1'b0}},
		'{KIND_SIX,   12'd0,    1'b1, '{16'sd0, 1'b0}},
		'{KIND_SIX,   12'd4095, 1'b1, '{16'sd5, 1'b0}},
		'{KIND_SIX,   12'd1100, 1'b0, '{16'sd0, 1'b0}},
		'{KIND_SIX,   12'd1300, 1'b0, '{16'sd0, 1'b0}},
		'{CMD_RSVD_5, 12'd2730, 1'b1, '{16'sd0, 1'b0}},
		'{CMD_RSVD_6, 12'd1365, 1'b1, '{16'sd0, 1'b0}},
		'{CMD_RSVD_7, 12'd4095, 1'b1, '{16'sd0, 1'b0}}
	};

	// min, max, center, deadband, full scale, switch low, switch high
	logic [CFG_DATA_W-1:0] presets [NUM_PRESETS][7] = '{
		'{16'd0,    16'd4095, 16'd2048, 16'd1023, 16'd32767, 16'd0,    16'd4095},
		'{16'd1500, 16'd1500, 16'd1500, 16'd0,    16'd0,     16'd4095, 16'd0},
		'{16'd1500, 16'd2000, 16'd1500, 16'd0,    16'd32767, 16'd1500, 16'd1500},
		'{16'd2000, 16'd1500, 16'd1500, 16'd20,   16'd32767, 16'd1750, 16'd1250},
		'{16'd4095, 16'd0,    16'd0,    16'd1023, 16'd32767, 16'd4095, 16'd4095},
		'{16'd1480, 16'd1000, 16'd1500, 16'd20,   16'd1000,  16'd1000, 16'd2000}
	};

	rc_channel_conditioner_core #(
		.DETENT_STEPS(DETENTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.pulse_width(pulse_width),
		.done(done),
		.value(value),
		.div_fault(div_fault),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	function automatic int linear_map(int v, int in_lo, int in_hi, int out_lo, int out_hi);
		return out_lo + ((v - in_lo) * (out_hi - out_lo)) / (in_hi - in_lo);
	endfunction

	function automatic channel_out_t condition_pulse(cfg_t c, logic [2:0] cmd,
			logic [PULSE_W-1:0] pw);
		int lo, hi, ctr, fs, p, db_lo, db_hi, span, res;
		logic fault;
		channel_out_t out;
		lo = c.pulse_min;
		hi = c.pulse_max;
		ctr = c.pulse_center;
		fs = c.full_scale;
		res = 0;
		fault = 1'b0;
		if (pw < c.pulse_min) begin
			p = lo;
		end else if (pw > c.pulse_max) begin
			p = hi;
		end else begin
			p = pw;
		end
		case (cmd)
			KIND_STICK: begin
				db_lo = ctr - int'(c.dead_half_width);
				db_hi = ctr + int'(c.dead_half_width);
				if (p < db_lo) begin
					if (db_lo == lo) fault = 1'b1;
					else res = linear_map(p, lo, db_lo, -fs, 0);
				end else if (p > db_hi) begin
					if (hi == db_hi) fault = 1'b1;
					else res = linear_map(p, db_hi, hi, 0, fs);
				end
			end
			KIND_POT: begin
				if (p <= ctr) begin
					if (ctr == lo) fault = 1'b1;
					else res = linear_map(p, lo, ctr, -fs, 0);
				end else begin
					if (hi == ctr) fault = 1'b1;
					else res = linear_map(p, ctr, hi, 0, fs);
				end
			end
			KIND_TWO: begin
				res = (p >= ctr) ? 1 : 0;
			end
			KIND_THREE: begin
				if (p <= int'(c.switch_low_level)) res = -1;
				else if (p >= int'(c.switch_high_level)) res = 1;
			end
			KIND_SIX: begin
				span = hi - lo;
				if (span == 0) begin
					fault = 1'b1;
				end else begin
					res = ((p - lo) * DETENTS + span / 2) / span;
					if (res < 0) res = 0;
					if (res > DETENTS) res = DETENTS;
				end
			end
			default: begin
				res = 0;
			end
		endcase
		if (fault) res = 0;
		if (res > OUT_MAG) res = OUT_MAG;
		if (res < -OUT_MAG) res = -OUT_MAG;
		out.value = res[VALUE_W-1:0];
		out.fault = fault;
		return out;
	endfunction

	function automatic logic [PULSE_W-1:0] pick_pulse();
		int p;
		int nudge;
		nudge = int'($urandom_range(0, 2)) - 1;
		case ($urandom_range(0, 11))
			0: p = 0;
			1: p = 4095;
			2: p = int'(shadow_cfg.pulse_min) + nudge;
			3: p = int'(shadow_cfg.pulse_max) + nudge;
			4: p = int'(shadow_cfg.pulse_center) + nudge;
			5: p = int'(shadow_cfg.pulse_center) - int'(shadow_cfg.dead_half_width) + nudge;
			6: p = int'(shadow_cfg.pulse_center) + int'(shadow_cfg.dead_half_width) + nudge;
			7: p = int'(shadow_cfg.switch_low_level) + nudge;
			8: p = int'(shadow_cfg.switch_high_level) + nudge;
			default: p = $urandom_range(0, 4095);
		endcase
		return p[PULSE_W-1:0];
	endfunction

	task automatic feed_item(input logic [2:0] cmd, input logic [PULSE_W-1:0] pw,
			input logic use_given, input channel_out_t given);
		start <= 1'b1;
		command <= cmd;
		pulse_width <= pw;
		do @(posedge clk); while (busy);
		pending_results.push_back(use_given ? given : condition_pulse(shadow_cfg, cmd, pw));
		items_sent++;
		if (!(items_sent >= QUIET_FIRST && items_sent < QUIET_LAST)
				&& $urandom_range(0, 99) < 35) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic wait_all_results();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		if ($urandom_range(0, 99) < 35) begin
			cfg_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PULSE_MIN:  shadow_cfg.pulse_min = data[11:0];
			REG_PULSE_MAX:  shadow_cfg.pulse_max = data[11:0];
			REG_PULSE_CTR:  shadow_cfg.pulse_center = data[11:0];
			REG_DEAD_HALF:  shadow_cfg.dead_half_width = data[9:0];
			REG_FULL_SCALE: shadow_cfg.full_scale = data[14:0];
			REG_SW_LOW:     shadow_cfg.switch_low_level = data[11:0];
			REG_SW_HIGH:    shadow_cfg.switch_high_level = data[11:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [CFG_DATA_W-1:0] mn, mx, ctr, dh, fs, swl, swh,
			input logic poke_unused);
		if (poke_unused) write_reg(REG_UNUSED, 16'($urandom));
		write_reg(REG_PULSE_MIN, mn);
		write_reg(REG_PULSE_MAX, mx);
		write_reg(REG_PULSE_CTR, ctr);
		write_reg(REG_DEAD_HALF, dh);
		write_reg(REG_FULL_SCALE, fs);
		write_reg(REG_SW_LOW, swl);
		write_reg(REG_SW_HIGH, swh);
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin : check_results
		channel_out_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with none pending: value=%0d div_fault=%0b", value, div_fault);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (value !== want.value) begin
					$error("value: expected %0d, got %0d", want.value, value);
					fail_count++;
				end
				if (div_fault !== want.fault) begin
					$error("div_fault: expected %0b, got %0b", want.fault, div_fault);
					fail_count++;
				end
			end
		end
	end

	initial begin : stimulus
		int mn, mx, ctr, dh, fs, swl, swh;
		logic [2:0] cmd;
		shadow_cfg = '{RST_PULSE_MIN, RST_PULSE_MAX, RST_PULSE_CTR, RST_DEAD_HALF,
			RST_FULL_SCALE, RST_SW_LOW, RST_SW_HIGH};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_cases[i])
			feed_item(directed_cases[i].cmd, directed_cases[i].pw, directed_cases[i].typed,
				directed_cases[i].want);
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			start <= 1'b0;
			wait_all_results();
			if (ph < NUM_PRESETS) begin
				apply_settings(presets[ph][0], presets[ph][1], presets[ph][2], presets[ph][3],
					presets[ph][4], presets[ph][5], presets[ph][6], 1'b0);
			end else if (ph == NUM_PRESETS || $urandom_range(0, 3) == 0) begin
				// raw words, upper bits above each field included
				apply_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
			end else begin
				mn = $urandom_range(0, 2500);
				mx = mn + int'($urandom_range(50, 1500));
				if (mx > 4095) mx = 4095;
				ctr = $urandom_range(mn, mx);
				dh = $urandom_range(0, 150);
				fs = $urandom_range(1, 32767);
				swl = $urandom_range(mn, mx);
				swh = $urandom_range(swl, mx);
				apply_settings(16'(mn), 16'(mx), 16'(ctr), 16'(dh), 16'(fs), 16'(swl), 16'(swh),
					1'b0);
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 19) == 0) cmd = 3'($urandom_range(5, 7));
				else cmd = 3'($urandom_range(0, 4));
				feed_item(cmd, pick_pulse(), 1'b0, '0);
			end
		end
		start <= 1'b0;
		wait_all_results();
		repeat (32) @(posedge clk);
		if (fail_count == 0) begin
			$display("** rc_channel_conditioner_core: PASSED **");
		end else begin
			$display("** rc_channel_conditioner_core: FAILED **");
		end
		$finish;
	end

	initial begin : watchdog
		#4000000;
		$display("** rc_channel_conditioner_core: FAILED **");
		$finish;
	end

endmodule

### sim.f
design/rcc_pkg.sv
design/rcc_front.sv
design/rcc_queue.sv
design/rcc_back.sv
design/rc_channel_conditioner_core.sv
test/tb_rc_channel_conditioner_core.sv
